/* src/ikin_pkg.sv */
// ----------------------------------------------------------------------------
// ikin_pkg: shared types and constants of the two-link IK solver
// Payload structs, cell data structs, status codes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package ikin_pkg;

  localparam int FRAC_BITS        = 12;
  localparam int CORDIC_STEPS_DEF = 14;
  localparam int MAX_STEPS        = 24;
  localparam int CW               = 34;  // CORDIC x/y width
  localparam int ZW               = 18;  // CORDIC angle width
  localparam int QBITS            = 13;  // quotient bits of c2 magnitude
  localparam int DEN_W            = 31;
  localparam int REM_W            = 44;
  localparam int SQ_W             = 25;
  localparam int ROOT_W           = 13;
  localparam int ANG_SHIFT        = 30 - FRAC_BITS;

  localparam int SHOULDER_MIN = -25736;
  localparam int SHOULDER_MAX = 12868;
  localparam int ELBOW_MAX    = 12868;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_REACH = 2'd1;
  localparam logic [1:0] ST_COS   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_INNER = 2'd0;
  localparam logic [1:0] REG_OUTER = 2'd1;

  localparam longint ATAN_Q30 [MAX_STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  localparam logic signed [ZW-1:0] HALF_PI =
    ZW'((HALF_PI_Q30 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT);

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] shoulder_angle;
    logic [13:0]        elbow_angle;
    logic [1:0]         solve_status;
  } out_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QBITS-1:0] q;
  } div_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  // Table entry brought to FRAC_BITS, rounded half up.
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    longint v;
    v = (ATAN_Q30[i] + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    return ZW'(v);
  endfunction

endpackage

/* src/ikin_div_cell.sv */
// ----------------------------------------------------------------------------
// ikin_div_cell: one restoring-division cell
// Resolve quotient bit K of the c2 magnitude and hand the remainder on.
// ----------------------------------------------------------------------------
module ikin_div_cell #(
  parameter int K = 0
) (
  input  logic             clk,
  input  logic             en,
  input  ikin_pkg::div_t   din,
  output ikin_pkg::div_t   dout
);

  logic [ikin_pkg::REM_W-1:0] dk;
  ikin_pkg::div_t             nxt;

  always_comb begin
    dk  = ikin_pkg::REM_W'(din.den) << K;
    nxt = din;
    if (din.rem >= dk) begin
      nxt.rem  = din.rem - dk;
      nxt.q[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* src/ikin_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// ikin_sqrt_cell: one digit cell of the integer square root
// Try root bit K against the running remainder and hand both on.
// ----------------------------------------------------------------------------
module ikin_sqrt_cell #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            en,
  input  ikin_pkg::sqrt_t din,
  output ikin_pkg::sqrt_t dout
);

  localparam int TW = ikin_pkg::SQ_W + 2;

  logic [TW-1:0]   trial;
  ikin_pkg::sqrt_t nxt;

  always_comb begin
    trial = (TW'(din.root) << (K + 1)) | (TW'(1) << (2 * K));
    nxt   = din;
    if (TW'(din.rem) >= trial) begin
      nxt.rem     = din.rem - ikin_pkg::SQ_W'(trial);
      nxt.root[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* src/ikin_cordic_cell.sv */
// ----------------------------------------------------------------------------
// ikin_cordic_cell: one vectoring CORDIC micro-rotation
// Rotate toward the x axis by atan(2^-I) and accumulate the angle.
// ----------------------------------------------------------------------------
module ikin_cordic_cell #(
  parameter int I = 0
) (
  input  logic            clk,
  input  logic            en,
  input  ikin_pkg::cord_t din,
  output ikin_pkg::cord_t dout
);

  localparam logic signed [ikin_pkg::ZW-1:0] STEP = ikin_pkg::atan_step(I);

  logic signed [ikin_pkg::CW-1:0] dx;
  logic signed [ikin_pkg::CW-1:0] dy;
  ikin_pkg::cord_t                nxt;

  always_comb begin
    dx = din.x >>> I;
    dy = din.y >>> I;
    if (din.y > 0) begin
      nxt.x = din.x + dy;
      nxt.y = din.y - dx;
      nxt.z = din.z + STEP;
    end else begin
      nxt.x = din.x - dy;
      nxt.y = din.y + dx;
      nxt.z = din.z - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* src/two_link_inverse_kinematics.sv */
// Throughput: one target per cycle; every cell of the division, square-root and
// CORDIC chains advances together, so a new item enters behind each one.
// The whole pipeline holds only while the output register is full and stalled.
// Reset (rst, synchronous): clears all valid bits and sets both link lengths to 1.0.
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics: pipelined two-link planar IK solver
// Squares and cross terms, a 13-cell restoring divider for the elbow cosine,
// a 13-cell square root for the sine, then three CORDIC vectoring chains for
// the elbow angle, the target bearing and the link offset angle.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics #(
  parameter int CORDIC_STEPS = ikin_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  // input channel
  input  logic            in_valid,
  output logic            in_stall,
  input  ikin_pkg::in_t   in_data,
  // result channel
  output logic            out_valid,
  input  logic            out_stall,
  output ikin_pkg::out_t  out_data,
  // configuration write channel
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [14:0]     cfg_data
);

  localparam int F     = ikin_pkg::FRAC_BITS;
  localparam int CW    = ikin_pkg::CW;
  localparam int ZW    = ikin_pkg::ZW;
  localparam int QB    = ikin_pkg::QBITS;
  localparam int RB    = ikin_pkg::ROOT_W;
  localparam int SQ_W  = ikin_pkg::SQ_W;
  localparam int REM_W = ikin_pkg::REM_W;
  localparam int DEN_W = ikin_pkg::DEN_W;

  localparam logic [SQ_W-1:0]   ONE_SQ = SQ_W'(1) << (2 * F);
  localparam logic signed [ZW:0] SH_MIN = (ZW+1)'(ikin_pkg::SHOULDER_MIN);
  localparam logic signed [ZW:0] SH_MAX = (ZW+1)'(ikin_pkg::SHOULDER_MAX);
  localparam logic signed [ZW-1:0] EL_MAX = ZW'(ikin_pkg::ELBOW_MAX);

  // Sideband carried next to each chain.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [1:0]         status;
    logic               neg;
  } early_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [1:0]         status;
    logic signed [13:0] c2;
  } mid_t;

  typedef struct packed {
    logic [1:0] status;
    logic       zt;
    logic       ze;
    logic       zk;
  } late_t;

  // --------------------------------------------------------------------------
  // Configuration: always ready, unknown indexes drop.
  // --------------------------------------------------------------------------
  logic [14:0] inner_len;
  logic [14:0] outer_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_len <= 15'd4096;
      outer_len <= 15'd4096;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ikin_pkg::REG_INNER) begin
        inner_len <= cfg_data;
      end else if (cfg_index == ikin_pkg::REG_OUTER) begin
        outer_len <= cfg_data;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Global advance: the whole row of cells moves unless the output register
  // holds a result that the sink stalls.
  // --------------------------------------------------------------------------
  logic en;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // --------------------------------------------------------------------------
  // Stage 1: capture the target.
  // --------------------------------------------------------------------------
  ikin_pkg::in_t d1;
  logic          v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares and cross products, all exact.
  // --------------------------------------------------------------------------
  ikin_pkg::in_t d2;
  logic          v2;
  logic [31:0]   r2;
  logic [29:0]   aa;
  logic [29:0]   bb;
  logic [29:0]   ab;
  logic [31:0]   ss;
  logic [15:0]   len_sum;
  logic signed [31:0] xx;
  logic signed [31:0] yy;

  always_comb begin
    len_sum = {1'b0, inner_len} + {1'b0, outer_len};
    xx      = d1.target_x * d1.target_x;
    yy      = d1.target_y * d1.target_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2 <= d1;
      r2 <= 32'(xx) + 32'(yy);
      aa <= inner_len * inner_len;
      bb <= outer_len * outer_len;
      ab <= inner_len * outer_len;
      ss <= len_sum * len_sum;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: numerator, denominator, reach and range checks, dividend with
  // the half-denominator rounding term folded in.
  // --------------------------------------------------------------------------
  logic signed [33:0] num;
  logic [33:0]        mag;
  logic [DEN_W-1:0]   den;
  logic               beyond;
  logic               cos_err;
  ikin_pkg::div_t     div3;
  early_t             e3;
  logic               v3;

  always_comb begin
    num     = $signed({2'b00, r2}) - $signed({4'b0000, aa}) - $signed({4'b0000, bb});
    mag     = num[33] ? 34'(-num) : 34'(num);
    den     = {ab, 1'b0};
    beyond  = r2 > ss;
    cos_err = (den == '0) || (mag > 34'(den));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div3.rem  <= (REM_W'(mag[DEN_W-1:0]) << F) + REM_W'(den >> 1);
      div3.den  <= den;
      div3.q    <= '0;
      e3.x      <= d2.target_x;
      e3.y      <= d2.target_y;
      e3.neg    <= num[33];
      e3.status <= beyond ? ikin_pkg::ST_REACH :
                   cos_err ? ikin_pkg::ST_COS : ikin_pkg::ST_OK;
    end
  end

  // --------------------------------------------------------------------------
  // Divider chain: one quotient bit per cell, MSB first.
  // --------------------------------------------------------------------------
  ikin_pkg::div_t dq [QB];
  early_t         ds [QB];
  logic           dv [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    ikin_div_cell #(.K(QB - 1 - j)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  ((j == 0) ? div3 : dq[(j == 0) ? 0 : j - 1]),
      .dout (dq[j])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (en) begin
        dv[j] <= (j == 0) ? v3 : dv[(j == 0) ? 0 : j - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ds[j] <= (j == 0) ? e3 : ds[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: restore the cosine sign, form 1 - c2^2 for the root.
  // --------------------------------------------------------------------------
  logic [QB-1:0]      qmag;
  logic [2*QB-1:0]    qsq;
  ikin_pkg::sqrt_t    s4;
  mid_t               m4;
  logic               v4;

  always_comb begin
    qmag = dq[QB-1].q;
    qsq  = qmag * qmag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= dv[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4.rem    <= ONE_SQ - SQ_W'(qsq);
      s4.root   <= '0;
      m4.x      <= ds[QB-1].x;
      m4.y      <= ds[QB-1].y;
      m4.status <= ds[QB-1].status;
      m4.c2     <= ds[QB-1].neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    end
  end

  // --------------------------------------------------------------------------
  // Square-root chain: one root bit per cell, MSB first.
  // --------------------------------------------------------------------------
  ikin_pkg::sqrt_t sq [RB];
  mid_t            ms [RB];
  logic            sv [RB];

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    ikin_sqrt_cell #(.K(RB - 1 - j)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  ((j == 0) ? s4 : sq[(j == 0) ? 0 : j - 1]),
      .dout (sq[j])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j] <= 1'b0;
      end else if (en) begin
        sv[j] <= (j == 0) ? v4 : sv[(j == 0) ? 0 : j - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ms[j] <= (j == 0) ? m4 : ms[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: the three vectors to resolve.
  //   elbow    (c2, s2)
  //   bearing  (x, y) scaled to F fraction bits
  //   offset   (a + b*c2, b*s2)
  // --------------------------------------------------------------------------
  logic [RB-1:0]        s2;
  logic signed [29:0]   bc;
  logic [27:0]          bs;
  ikin_pkg::cord_t      t5;
  ikin_pkg::cord_t      e5;
  ikin_pkg::cord_t      k5;
  logic [1:0]           st5;
  logic                 v5;

  always_comb begin
    s2 = sq[RB-1].root;
    bc = $signed({1'b0, outer_len}) * ms[RB-1].c2;
    bs = outer_len * s2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= sv[RB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5.x <= CW'(ms[RB-1].x) <<< F;
      t5.y <= CW'(ms[RB-1].y) <<< F;
      t5.z <= '0;
      e5.x <= CW'(ms[RB-1].c2);
      e5.y <= $signed({{(CW-RB){1'b0}}, s2});
      e5.z <= '0;
      k5.x <= $signed({{(CW-15-F){1'b0}}, inner_len, {F{1'b0}}}) + CW'(bc);
      k5.y <= $signed({{(CW-28){1'b0}}, bs});
      k5.z <= '0;
      st5  <= ms[RB-1].status;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: quadrant fold for the left half plane, zero-vector flags.
  // --------------------------------------------------------------------------
  function automatic ikin_pkg::cord_t fold(input ikin_pkg::cord_t c);
    ikin_pkg::cord_t r;
    r = c;
    if (c.x < 0) begin
      if (c.y >= 0) begin
        r.x = c.y;
        r.y = -c.x;
        r.z = ikin_pkg::HALF_PI;
      end else begin
        r.x = -c.y;
        r.y = c.x;
        r.z = -ikin_pkg::HALF_PI;
      end
    end
    return r;
  endfunction

  ikin_pkg::cord_t t6;
  ikin_pkg::cord_t e6;
  ikin_pkg::cord_t k6;
  late_t           l6;
  logic            v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t6        <= fold(t5);
      e6        <= fold(e5);
      k6        <= fold(k5);
      l6.status <= st5;
      l6.zt     <= (t5.x == '0) && (t5.y == '0);
      l6.ze     <= (e5.x == '0) && (e5.y == '0);
      l6.zk     <= (k5.x == '0) && (k5.y == '0);
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC chains: three rows of micro-rotation cells side by side.
  // --------------------------------------------------------------------------
  ikin_pkg::cord_t ct [CORDIC_STEPS];
  ikin_pkg::cord_t ce [CORDIC_STEPS];
  ikin_pkg::cord_t ck [CORDIC_STEPS];
  late_t           cs [CORDIC_STEPS];
  logic            cv [CORDIC_STEPS];

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    ikin_cordic_cell #(.I(j)) u_bearing (
      .clk  (clk),
      .en   (en),
      .din  ((j == 0) ? t6 : ct[(j == 0) ? 0 : j - 1]),
      .dout (ct[j])
    );

    ikin_cordic_cell #(.I(j)) u_elbow (
      .clk  (clk),
      .en   (en),
      .din  ((j == 0) ? e6 : ce[(j == 0) ? 0 : j - 1]),
      .dout (ce[j])
    );

    ikin_cordic_cell #(.I(j)) u_offset (
      .clk  (clk),
      .en   (en),
      .din  ((j == 0) ? k6 : ck[(j == 0) ? 0 : j - 1]),
      .dout (ck[j])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[j] <= 1'b0;
      end else if (en) begin
        cv[j] <= (j == 0) ? v6 : cv[(j == 0) ? 0 : j - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs[j] <= (j == 0) ? l6 : cs[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: combine angles, saturate, zero both angles on any error.
  // --------------------------------------------------------------------------
  logic signed [ZW-1:0] ang_t;
  logic signed [ZW-1:0] ang_e;
  logic signed [ZW-1:0] ang_k;
  logic signed [ZW:0]   q1;
  logic signed [ZW:0]   q1_sat;
  logic signed [ZW-1:0] q2_sat;
  late_t                lf;
  ikin_pkg::out_t       res;

  always_comb begin
    lf    = cs[CORDIC_STEPS-1];
    ang_t = lf.zt ? '0 : ct[CORDIC_STEPS-1].z;
    ang_e = lf.ze ? '0 : ce[CORDIC_STEPS-1].z;
    ang_k = lf.zk ? '0 : ck[CORDIC_STEPS-1].z;
    q1    = (ZW+1)'(ang_t) - (ZW+1)'(ang_k);

    if (q1 < SH_MIN) begin
      q1_sat = SH_MIN;
    end else if (q1 > SH_MAX) begin
      q1_sat = SH_MAX;
    end else begin
      q1_sat = q1;
    end

    if (ang_e < 0) begin
      q2_sat = '0;
    end else if (ang_e > EL_MAX) begin
      q2_sat = EL_MAX;
    end else begin
      q2_sat = ang_e;
    end

    res.solve_status = lf.status;
    if (lf.status == ikin_pkg::ST_OK) begin
      res.shoulder_angle = q1_sat[15:0];
      res.elbow_angle    = q2_sat[13:0];
    end else begin
      res.shoulder_angle = '0;
      res.elbow_angle    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.solve_status != ikin_pkg::ST_OK)
      |-> (out_data.shoulder_angle == '0) && (out_data.elbow_angle == '0))
    else $error("error result carries nonzero angles");

  a_elbow_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.elbow_angle <= 14'(ikin_pkg::ELBOW_MAX)))
    else $error("elbow angle beyond pi");

  a_cfg_inner: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == ikin_pkg::REG_INNER)
      |=> inner_len == $past(cfg_data))
    else $error("inner link length write lost");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(v6) && $stable(l6))
    else $error("pipeline advanced under output stall");
`endif

endmodule
